// ===== src/ibsiu_pkg.sv =====
package ibsiu_pkg;

  // Flag bit positions in the flag register.
  localparam int unsigned FLAG_S = 7;
  localparam int unsigned FLAG_Z = 6;
  localparam int unsigned FLAG_Y = 5;
  localparam int unsigned FLAG_H = 4;
  localparam int unsigned FLAG_X = 3;
  localparam int unsigned FLAG_P = 2;
  localparam int unsigned FLAG_N = 1;
  localparam int unsigned FLAG_C = 0;

  // Cycle counts reported for each instruction class.
  localparam logic [4:0] CYC_TEST   = 5'd20;
  localparam logic [4:0] CYC_MODIFY = 5'd23;
  localparam logic [4:0] CYC_NONE   = 5'd0;

  // Opcode fields.
  localparam logic [2:0] OPERAND_MEM = 3'd6;
  localparam logic [7:0] OP_SLL      = 8'h36;

  // Operation groups, taken from the top two opcode bits.
  localparam logic [1:0] GRP_SHIFT = 2'd0;
  localparam logic [1:0] GRP_BIT   = 2'd1;
  localparam logic [1:0] GRP_RES   = 2'd2;
  localparam logic [1:0] GRP_SET   = 2'd3;

  // Rotate and shift selectors within the shift group.
  localparam logic [2:0] SH_RLC = 3'd0;
  localparam logic [2:0] SH_RRC = 3'd1;
  localparam logic [2:0] SH_RL  = 3'd2;
  localparam logic [2:0] SH_RR  = 3'd3;
  localparam logic [2:0] SH_SLA = 3'd4;
  localparam logic [2:0] SH_SRA = 3'd5;
  localparam logic [2:0] SH_SLL = 3'd6;
  localparam logic [2:0] SH_SRL = 3'd7;

  // One instruction as it enters the unit.
  typedef struct packed {
    logic [7:0]        opcode_byte;
    logic signed [7:0] displacement;
    logic [15:0]       index_base;
    logic [7:0]        memory_byte;
    logic [7:0]        flags_in;
  } item_t;

  // The outcome of one instruction.
  typedef struct packed {
    logic [15:0] address;
    logic        write_enable;
    logic [7:0]  write_byte;
    logic [7:0]  flags_out;
    logic        trapped;
    logic [4:0]  cycle_count;
  } result_t;

endpackage

// ===== src/ibsiu_req_if.sv =====
interface ibsiu_req_if;
  logic              valid;
  logic              ready;
  logic [7:0]        opcode_byte;
  logic signed [7:0] displacement;
  logic [15:0]       index_base;
  logic [7:0]        memory_byte;
  logic [7:0]        flags_in;

  modport source (
    output valid, opcode_byte, displacement, index_base, memory_byte, flags_in,
    input  ready
  );
  modport sink (
    input  valid, opcode_byte, displacement, index_base, memory_byte, flags_in,
    output ready
  );
endinterface

// ===== src/ibsiu_rsp_if.sv =====
interface ibsiu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic        write_enable;
  logic [7:0]  write_byte;
  logic [7:0]  flags_out;
  logic        trapped;
  logic [4:0]  cycle_count;

  modport source (
    output valid, address, write_enable, write_byte, flags_out, trapped, cycle_count,
    input  ready
  );
  modport sink (
    input  valid, address, write_enable, write_byte, flags_out, trapped, cycle_count,
    output ready
  );
endinterface

// ===== src/ibsiu_exec.sv =====
module ibsiu_exec (
  input  ibsiu_pkg::item_t   item,
  input  logic               undocumented_enable,
  output ibsiu_pkg::result_t result
);

  logic [1:0] group;
  logic [2:0] sel;
  logic [7:0] bitmask;
  logic [7:0] mem;
  logic [7:0] fin;
  logic       illegal;
  logic [7:0] shifted;
  logic       carry;
  logic [7:0] shift_flags;
  logic [7:0] bit_flags;

  assign group   = item.opcode_byte[7:6];
  assign sel     = item.opcode_byte[5:3];
  assign bitmask = 8'd1 << sel;
  assign mem     = item.memory_byte;
  assign fin     = item.flags_in;

  // Anything not addressing memory traps, as does SLL while it is disabled.
  assign illegal = (item.opcode_byte[2:0] != ibsiu_pkg::OPERAND_MEM) ||
                   ((item.opcode_byte == ibsiu_pkg::OP_SLL) && !undocumented_enable);

  // Rotate and shift datapath.
  always_comb begin
    case (sel)
      ibsiu_pkg::SH_RLC: begin
        carry   = mem[7];
        shifted = {mem[6:0], mem[7]};
      end
      ibsiu_pkg::SH_RRC: begin
        carry   = mem[0];
        shifted = {mem[0], mem[7:1]};
      end
      ibsiu_pkg::SH_RL: begin
        carry   = mem[7];
        shifted = {mem[6:0], fin[ibsiu_pkg::FLAG_C]};
      end
      ibsiu_pkg::SH_RR: begin
        carry   = mem[0];
        shifted = {fin[ibsiu_pkg::FLAG_C], mem[7:1]};
      end
      ibsiu_pkg::SH_SLA: begin
        carry   = mem[7];
        shifted = {mem[6:0], 1'b0};
      end
      ibsiu_pkg::SH_SRA: begin
        carry   = mem[0];
        shifted = {mem[7], mem[7:1]};
      end
      ibsiu_pkg::SH_SLL: begin
        carry   = mem[7];
        shifted = {mem[6:0], 1'b1};
      end
      default: begin
        carry   = mem[0];
        shifted = {1'b0, mem[7:1]};
      end
    endcase
  end

  // Flags after a rotate or shift: only the two undefined bits pass through.
  always_comb begin
    shift_flags                    = 8'd0;
    shift_flags[ibsiu_pkg::FLAG_Y] = fin[ibsiu_pkg::FLAG_Y];
    shift_flags[ibsiu_pkg::FLAG_X] = fin[ibsiu_pkg::FLAG_X];
    shift_flags[ibsiu_pkg::FLAG_C] = carry;
    shift_flags[ibsiu_pkg::FLAG_Z] = (shifted == 8'd0);
    shift_flags[ibsiu_pkg::FLAG_S] = shifted[7];
    shift_flags[ibsiu_pkg::FLAG_P] = ~^shifted;
  end

  // Flags after a bit test; carry and the undefined bits are kept.
  always_comb begin
    bit_flags                    = fin;
    bit_flags[ibsiu_pkg::FLAG_H] = 1'b1;
    bit_flags[ibsiu_pkg::FLAG_N] = 1'b0;
    bit_flags[ibsiu_pkg::FLAG_Z] = ((mem & bitmask) == 8'd0);
    bit_flags[ibsiu_pkg::FLAG_P] = ((mem & bitmask) == 8'd0);
    bit_flags[ibsiu_pkg::FLAG_S] = (sel == 3'd7) && mem[7];
  end

  // Result selection by operation group.
  always_comb begin
    result.address      = item.index_base + {{8{item.displacement[7]}}, item.displacement};
    result.write_enable = 1'b0;
    result.write_byte   = 8'd0;
    result.flags_out    = fin;
    result.trapped      = 1'b0;
    result.cycle_count  = ibsiu_pkg::CYC_NONE;
    if (illegal) begin
      result.trapped = 1'b1;
    end else begin
      case (group)
        ibsiu_pkg::GRP_BIT: begin
          result.flags_out   = bit_flags;
          result.cycle_count = ibsiu_pkg::CYC_TEST;
        end
        ibsiu_pkg::GRP_RES: begin
          result.write_enable = 1'b1;
          result.write_byte   = mem & ~bitmask;
          result.cycle_count  = ibsiu_pkg::CYC_MODIFY;
        end
        ibsiu_pkg::GRP_SET: begin
          result.write_enable = 1'b1;
          result.write_byte   = mem | bitmask;
          result.cycle_count  = ibsiu_pkg::CYC_MODIFY;
        end
        default: begin
          result.write_enable = 1'b1;
          result.write_byte   = shifted;
          result.flags_out    = shift_flags;
          result.cycle_count  = ibsiu_pkg::CYC_MODIFY;
        end
      endcase
    end
  end

endmodule

// ===== src/indexed_bit_shift_instruction_unit.sv =====
// A transfer accepted on req passes the input register, then the result
// register, before it reaches rsp. Throughput: one instruction per cycle while
// rsp does not stall, set by the input register feeding the decode and byte
// logic straight into the result register. Reset: synchronous and active high;
// both pipeline stages are emptied and undocumented_enable returns to 1.
module indexed_bit_shift_instruction_unit (
  input  logic        clk,
  input  logic        rst,
  ibsiu_req_if.sink   req,
  ibsiu_rsp_if.source rsp,
  input  logic        cfg_write,
  input  logic        cfg_data
);

  logic               undocumented_enable;
  logic               s1_valid;
  ibsiu_pkg::item_t   s1_item;
  ibsiu_pkg::result_t exec_result;
  logic               out_valid;
  ibsiu_pkg::result_t out_result;
  logic               out_load;
  logic               s1_load;

  // The result register may load when empty or when its contents leave.
  assign out_load  = !out_valid || rsp.ready;
  assign s1_load   = !s1_valid || out_load;
  assign req.ready = s1_load;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      undocumented_enable <= 1'b1;
    end else if (cfg_write) begin
      undocumented_enable <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && req.valid) begin
      s1_item.opcode_byte  <= req.opcode_byte;
      s1_item.displacement <= req.displacement;
      s1_item.index_base   <= req.index_base;
      s1_item.memory_byte  <= req.memory_byte;
      s1_item.flags_in     <= req.flags_in;
    end
  end

  ibsiu_exec u_exec (
    .item                (s1_item),
    .undocumented_enable (undocumented_enable),
    .result              (exec_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_result <= exec_result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.address      = out_result.address;
  assign rsp.write_enable = out_result.write_enable;
  assign rsp.write_byte   = out_result.write_byte;
  assign rsp.flags_out    = out_result.flags_out;
  assign rsp.trapped      = out_result.trapped;
  assign rsp.cycle_count  = out_result.cycle_count;

`ifndef ASSERT_OFF
  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result stage not empty after reset");

  // A new result can only come from an occupied input stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without an instruction in the input stage");

  // A stalled input stage keeps its instruction.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> (s1_valid && $stable(s1_item)))
    else $error("input stage lost its instruction while stalled");

  // A trap writes nothing and reports no cycles.
  a_trap_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.trapped) |->
      (!out_result.write_enable && (out_result.cycle_count == ibsiu_pkg::CYC_NONE)))
    else $error("trapped instruction has side effects");

  // Every write-back belongs to a modifying instruction.
  a_write_cycles: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.write_enable) |->
      (out_result.cycle_count == ibsiu_pkg::CYC_MODIFY))
    else $error("write-back with wrong cycle count");
`endif

endmodule

// ===== tb/sv/ibsiu_outcome_checker.sv =====
`timescale 1ns / 1ps
module ibsiu_outcome_checker
  import ibsiu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ibsiu_req_if        req,
  ibsiu_rsp_if        rsp,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output int unsigned mismatch_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  // Outcomes predicted for accepted instructions, oldest first.
  result_t     expected_outcomes[$];
  logic        sll_enabled = 1'b1;
  int unsigned fail_tally  = 0;
  int unsigned check_tally = 0;

  // Works out what one instruction should produce under the given SLL setting.
  function automatic result_t predict_outcome(input item_t ins, input logic sll_on);
    result_t    outcome;
    logic [1:0] grp;
    logic [2:0] sel;
    logic [7:0] mask;
    logic [7:0] mem;
    logic [7:0] shifted;
    logic       carry;
    grp  = ins.opcode_byte[7:6];
    sel  = ins.opcode_byte[5:3];
    mask = 8'd1 << sel;
    mem  = ins.memory_byte;

    outcome.address      = ins.index_base + {{8{ins.displacement[7]}}, ins.displacement};
    outcome.write_enable = 1'b0;
    outcome.write_byte   = '0;
    outcome.flags_out    = ins.flags_in;
    outcome.trapped      = 1'b0;
    outcome.cycle_count  = CYC_NONE;

    if (ins.opcode_byte[2:0] != OPERAND_MEM || (ins.opcode_byte == OP_SLL && !sll_on)) begin
      outcome.trapped = 1'b1;
    end else begin
      case (grp)
        GRP_BIT: begin
          // Z and P both report a clear bit; S only follows a test of bit 7.
          outcome.flags_out[FLAG_Z] = ~|(mem & mask);
          outcome.flags_out[FLAG_P] = ~|(mem & mask);
          outcome.flags_out[FLAG_S] = (sel == 3'(FLAG_S)) && mem[FLAG_S];
          outcome.flags_out[FLAG_H] = 1'b1;
          outcome.flags_out[FLAG_N] = 1'b0;
          outcome.cycle_count       = CYC_TEST;
        end
        GRP_RES: begin
          outcome.write_enable = 1'b1;
          outcome.write_byte   = mem & ~mask;
          outcome.cycle_count  = CYC_MODIFY;
        end
        GRP_SET: begin
          outcome.write_enable = 1'b1;
          outcome.write_byte   = mem | mask;
          outcome.cycle_count  = CYC_MODIFY;
        end
        default: begin
          case (sel)
            SH_RLC: begin carry = mem[7]; shifted = {mem[6:0], mem[7]}; end
            SH_RRC: begin carry = mem[0]; shifted = {mem[0], mem[7:1]}; end
            SH_RL:  begin carry = mem[7]; shifted = {mem[6:0], ins.flags_in[FLAG_C]}; end
            SH_RR:  begin carry = mem[0]; shifted = {ins.flags_in[FLAG_C], mem[7:1]}; end
            SH_SLA: begin carry = mem[7]; shifted = {mem[6:0], 1'b0}; end
            SH_SRA: begin carry = mem[0]; shifted = {mem[7], mem[7:1]}; end
            SH_SLL: begin carry = mem[7]; shifted = {mem[6:0], 1'b1}; end
            default: begin carry = mem[0]; shifted = {1'b0, mem[7:1]}; end
          endcase
          // H and N clear; the two spare flag bits pass through untouched.
          outcome.flags_out         = '0;
          outcome.flags_out[FLAG_Y] = ins.flags_in[FLAG_Y];
          outcome.flags_out[FLAG_X] = ins.flags_in[FLAG_X];
          outcome.flags_out[FLAG_C] = carry;
          outcome.flags_out[FLAG_Z] = (shifted == 8'd0);
          outcome.flags_out[FLAG_S] = shifted[7];
          outcome.flags_out[FLAG_P] = ~^shifted;
          outcome.write_enable      = 1'b1;
          outcome.write_byte        = shifted;
          outcome.cycle_count       = CYC_MODIFY;
        end
      endcase
    end
    return outcome;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_tally++;
    end
  endtask

  // Each response transfer is checked against the oldest prediction, then each request
  // transfer adds a new one.
  always @(posedge clk) begin : track_transfers
    item_t   ins;
    result_t want;
    result_t got;
    if (rst) begin
      expected_outcomes.delete();
      sll_enabled = 1'b1;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{address: rsp.address, write_enable: rsp.write_enable,
                write_byte: rsp.write_byte, flags_out: rsp.flags_out,
                trapped: rsp.trapped, cycle_count: rsp.cycle_count};
        if (expected_outcomes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
          fail_tally++;
        end else begin
          want = expected_outcomes.pop_front();
          compare_field("address", want.address, got.address);
          compare_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
          compare_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
          compare_field("flags_out", 16'(want.flags_out), 16'(got.flags_out));
          compare_field("trapped", 16'(want.trapped), 16'(got.trapped));
          compare_field("cycle_count", 16'(want.cycle_count), 16'(got.cycle_count));
          check_tally++;
        end
      end
      if (req.valid && req.ready) begin
        ins = '{opcode_byte: req.opcode_byte, displacement: req.displacement,
                index_base: req.index_base, memory_byte: req.memory_byte,
                flags_in: req.flags_in};
        expected_outcomes.push_back(predict_outcome(ins, sll_enabled));
      end
      // The register is only written while nothing is in flight.
      if (cfg_write) begin
        sll_enabled = cfg_data;
      end
    end
    mismatch_count <= fail_tally;
    pending_count  <= expected_outcomes.size();
    checked_count  <= check_tally;
  end

endmodule

// ===== tb/sv/indexed_bit_shift_instruction_unit_tb.sv =====
`timescale 1ns / 1ps
module indexed_bit_shift_instruction_unit_tb;
  import ibsiu_pkg::*;

  // Register operand codes in the low opcode bits; the unit traps on all of them.
  localparam logic [2:0] OPERAND_REG_B = 3'd0;
  localparam logic [2:0] OPERAND_REG_A = 3'd7;

  localparam int unsigned RANDOM_PER_PHASE = 300;
  localparam int unsigned HOLD_OFF_CYCLES  = 40;
  localparam int unsigned SETTLE_CYCLES    = 8;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count        = 0;
  int unsigned sender_idle_pct   = 31;
  int unsigned receiver_idle_pct = 82;
  bit          hold_off_request  = 1'b0;

  ibsiu_req_if req_ch ();
  ibsiu_rsp_if rsp_ch ();

  indexed_bit_shift_instruction_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  ibsiu_outcome_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(posedge clk);
    end
  end

  function automatic logic [7:0] opcode_of(input logic [1:0] grp, input logic [2:0] sel,
                                           input logic [2:0] operand);
    return {grp, sel, operand};
  endfunction

  function automatic item_t make_item(input logic [7:0] op, input logic signed [7:0] disp,
                                      input logic [15:0] base, input logic [7:0] mem,
                                      input logic [7:0] flags);
    return '{opcode_byte: op, displacement: disp, index_base: base,
             memory_byte: mem, flags_in: flags};
  endfunction

  // Mostly well-formed memory-operand opcodes, with corner bytes mixed in.
  function automatic item_t random_instruction();
    item_t       ins;
    logic [7:0]  raw;
    int unsigned roll;
    raw  = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 8) begin
      raw = OP_SLL;
    end else if (roll < 88) begin
      raw[2:0] = OPERAND_MEM;
    end
    ins.opcode_byte  = raw;
    ins.displacement = 8'($urandom);
    ins.index_base   = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      ins.index_base = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    ins.memory_byte = 8'($urandom);
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: ins.memory_byte = 8'h00;
        1: ins.memory_byte = 8'hFF;
        2: ins.memory_byte = 8'h80;
        default: ins.memory_byte = 8'h01;
      endcase
    end
    ins.flags_in = 8'($urandom);
    return ins;
  endfunction

  // Offers one instruction after a random gap and returns once it has been transferred.
  task automatic offer_instruction(input item_t ins);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode_byte  <= ins.opcode_byte;
    req_ch.displacement <= ins.displacement;
    req_ch.index_base   <= ins.index_base;
    req_ch.memory_byte  <= ins.memory_byte;
    req_ch.flags_in     <= ins.flags_in;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent_count++;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer_instruction(random_instruction());
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // The enable is only changed once every outstanding result has come back.
  task automatic set_sll_enable(input logic on);
    wait_until_drained();
    cfg_write <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_data            <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode_byte  <= '0;
    req_ch.displacement <= '0;
    req_ch.index_base   <= '0;
    req_ch.memory_byte  <= '0;
    req_ch.flags_in     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: every rotate and shift, bit tests, bit changes, traps and address wrap.
    set_sll_enable(1'b1);
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_RLC, OPERAND_MEM), 8'sd0, 16'h1234,
                                8'h81, 8'h00));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_RRC, OPERAND_MEM), 8'sd1, 16'h1234,
                                8'h01, 8'hFF));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_RL, OPERAND_MEM), -8'sd1, 16'h0000,
                                8'h80, 8'h01));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_RR, OPERAND_MEM), 8'sh80, 16'h0000,
                                8'h01, 8'h01));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_SLA, OPERAND_MEM), 8'sd127, 16'hFFFF,
                                8'h80, 8'hD7));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_SRA, OPERAND_MEM), 8'sd127, 16'hFF90,
                                8'h81, 8'h00));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_SLL, OPERAND_MEM), 8'sh80, 16'h0040,
                                8'h7F, 8'h28));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_SRL, OPERAND_MEM), 8'sd5, 16'hFFFE,
                                8'h01, 8'hFF));
    offer_instruction(make_item(opcode_of(GRP_BIT, 3'd7, OPERAND_MEM), 8'sd0, 16'h8000,
                                8'h80, 8'h00));
    offer_instruction(make_item(opcode_of(GRP_BIT, 3'd7, OPERAND_MEM), 8'sd0, 16'h8000,
                                8'h7F, 8'hFF));
    offer_instruction(make_item(opcode_of(GRP_BIT, 3'd0, OPERAND_MEM), 8'sd2, 16'h7FFF,
                                8'h00, 8'hFF));
    offer_instruction(make_item(opcode_of(GRP_BIT, 3'd3, OPERAND_MEM), -8'sd2, 16'h0001,
                                8'hFF, 8'h01));
    offer_instruction(make_item(opcode_of(GRP_RES, 3'd7, OPERAND_MEM), 8'sd10, 16'hAAAA,
                                8'hFF, 8'h55));
    offer_instruction(make_item(opcode_of(GRP_RES, 3'd0, OPERAND_MEM), -8'sd10, 16'h5555,
                                8'h01, 8'hAA));
    offer_instruction(make_item(opcode_of(GRP_SET, 3'd0, OPERAND_MEM), 8'sd64, 16'h00FF,
                                8'h00, 8'h00));
    offer_instruction(make_item(opcode_of(GRP_SET, 3'd7, OPERAND_MEM), -8'sd64, 16'hFF00,
                                8'h7F, 8'hFF));
    offer_instruction(make_item(opcode_of(GRP_SHIFT, SH_RLC, OPERAND_REG_B), 8'sd3, 16'h4000,
                                8'hFF, 8'hA5));
    offer_instruction(make_item(opcode_of(GRP_SET, SH_SRL, OPERAND_REG_A), -8'sd3, 16'h4000,
                                8'h00, 8'h5A));
    offer_instruction(make_item(opcode_of(GRP_BIT, 3'd5, OPERAND_REG_A), 8'sd127, 16'h0000,
                                8'h20, 8'h00));

    // Phase one: SLL disabled, so it must trap; the receiver idles far more than the sender.
    set_sll_enable(1'b0);
    offer_instruction(make_item(OP_SLL, 8'sd0, 16'h2000, 8'h81, 8'h3C));
    offer_instruction(make_item(OP_SLL, 8'sh80, 16'h0000, 8'h00, 8'hC3));
    run_random(RANDOM_PER_PHASE);

    // Phase two: SLL enabled again; idling rates swapped.
    set_sll_enable(1'b1);
    sender_idle_pct   = 82;
    receiver_idle_pct = 31;
    run_random(RANDOM_PER_PHASE);

    // Phase three: no idling, a long response hold-off to fill the pipeline, and the
    // enable switched between halves.
    set_sll_enable(1'b0);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_request  = 1'b1;
    run_random(RANDOM_PER_PHASE / 2);
    set_sll_enable(1'b1);
    run_random(RANDOM_PER_PHASE / 2);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d instructions over three idling profiles,",
             checked_count, sent_count);
    $display("with SLL enabled and disabled and one long response hold-off.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
